// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/spm_pkg.sv
// ---------------------------------------------------------------------------
// spm_pkg
// Types and codes shared by the sparse polynomial merge block.
// ---------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } st_e;

  // One stored term.
  typedef struct packed {
    logic signed [15:0] coef;
    logic [7:0]         expo;
  } term_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] term_coef;
    logic [7:0]         term_exponent;
  } in_req_t;

  typedef struct packed {
    logic signed [16:0] sum_coef;
    logic [7:0]         sum_exponent;
    logic               is_empty;
    logic               truncated;
    logic               last;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: design/sparse_polynomial_add_merge.sv
// ---------------------------------------------------------------------------
// sparse_polynomial_add_merge
// Adds two sparse polynomials held as descending term lists in two memories.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o | in_req_i (op, coef, exponent)
//   out     | output    | out_valid_o/out_ready_i | out_rsp_o (term, flags)
//
// Flow: a load request is written while idle, and the block stays ready
//   for the next request. A merge request walks the lists in steps of a
//   memory read state and a compare state; ready rises again at its end.
// Reset: clears counts, state and output valid; the list memories are not
//   cleared, entries beyond the counts are never used.
// Stalls: input ready is held low for the whole merge. When the output
//   register is still full, the compare step waits in place; the held term
//   gives the one-term lookahead needed to flag last and truncated.
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add_merge import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_rsp_t     out_rsp_o
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  term_t         a_rdata, b_rdata;
  term_t         load_term;

  // Both lists are written from the same request fields.
  assign load_term.coef = in_req_i.term_coef;
  assign load_term.expo = in_req_i.term_exponent;

  spm_term_mem #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (load_term),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  spm_term_mem #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (load_term),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Loads happen only while idle and read data is used only during a merge,
  // so a write never lands on an entry whose data is in use that cycle.
  spm_merge_ctrl #(
    .MAX_TERMS (MAX_TERMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_o     (out_rsp_o),
    .mem_a_we_o    (a_we),
    .mem_a_waddr_o (a_waddr),
    .mem_a_raddr_o (a_raddr),
    .mem_a_rdata_i (a_rdata),
    .mem_b_we_o    (b_we),
    .mem_b_waddr_o (b_waddr),
    .mem_b_raddr_o (b_raddr),
    .mem_b_rdata_i (b_rdata)
  );

endmodule

`default_nettype wire

// File: design/spm_term_mem.sv
// ---------------------------------------------------------------------------
// spm_term_mem
// One term list: single write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_term_mem import spm_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire term_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output term_t              rdata_o
);

  term_t mem_q [DEPTH];
  term_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/spm_merge_ctrl.sv
// ---------------------------------------------------------------------------
// spm_merge_ctrl
// Load sequencing, head-by-head merge walk and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_merge_ctrl import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned AW        = 4,
  parameter int unsigned CW        = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire in_req_t       in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output out_rsp_t           out_rsp_o,
  output logic               mem_a_we_o,
  output logic [AW-1:0]      mem_a_waddr_o,
  output logic [AW-1:0]      mem_a_raddr_o,
  input  wire term_t         mem_a_rdata_i,
  output logic               mem_b_we_o,
  output logic [AW-1:0]      mem_b_waddr_o,
  output logic [AW-1:0]      mem_b_raddr_o,
  input  wire term_t         mem_b_rdata_i
);

  localparam logic [CW-1:0] CapCnt = CW'(MAX_TERMS);

  st_e             state_q, state_d;
  logic [CW-1:0]   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, n_q, n_d;
  logic            pend_vld_q, pend_vld_d;
  logic signed [16:0] pend_coef_q, pend_coef_d;
  logic [7:0]      pend_expo_q, pend_expo_d;
  logic            out_vld_q, out_vld_d;
  out_rsp_t        out_q, out_d;

  logic               a_ok, b_ok, take_a, take_b, slot_free, coef_nz;
  logic signed [16:0] cand_coef;
  logic [7:0]         cand_expo;

  assign mem_a_waddr_o = cnt_a_q[AW-1:0];
  assign mem_b_waddr_o = cnt_b_q[AW-1:0];
  assign mem_a_raddr_o = i_q[AW-1:0];
  assign mem_b_raddr_o = j_q[AW-1:0];

  // Head compare on the registered read data.
  always_comb begin
    a_ok      = (i_q < cnt_a_q);
    b_ok      = (j_q < cnt_b_q);
    take_a    = 1'b0;
    take_b    = 1'b0;
    cand_coef = {mem_b_rdata_i.coef[15], mem_b_rdata_i.coef};
    cand_expo = mem_b_rdata_i.expo;
    if (a_ok && b_ok && (mem_a_rdata_i.expo == mem_b_rdata_i.expo)) begin
      take_a    = 1'b1;
      take_b    = 1'b1;
      cand_coef = {mem_a_rdata_i.coef[15], mem_a_rdata_i.coef}
                + {mem_b_rdata_i.coef[15], mem_b_rdata_i.coef};
      cand_expo = mem_a_rdata_i.expo;
    end else if (!b_ok || (a_ok && (mem_a_rdata_i.expo > mem_b_rdata_i.expo))) begin
      take_a    = 1'b1;
      cand_coef = {mem_a_rdata_i.coef[15], mem_a_rdata_i.coef};
      cand_expo = mem_a_rdata_i.expo;
    end else begin
      take_b    = 1'b1;
    end
  end

  assign coef_nz   = (in_req_i.term_coef != 16'sd0);
  assign slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    pend_vld_d  = pend_vld_q;
    pend_coef_d = pend_coef_q;
    pend_expo_d = pend_expo_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    mem_a_we_o  = 1'b0;
    mem_b_we_o  = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(in_req_i.opcode))
            OP_LOAD_A: begin
              if (coef_nz && (cnt_a_q < CapCnt)) begin
                mem_a_we_o = 1'b1;
                cnt_a_d    = cnt_a_q + 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (coef_nz && (cnt_b_q < CapCnt)) begin
                mem_b_we_o = 1'b1;
                cnt_b_d    = cnt_b_q + 1'b1;
              end
            end
            OP_MERGE: begin
              i_d        = '0;
              j_d        = '0;
              n_d        = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_READ;
            end
            default: ;
          endcase
        end
      end

      ST_READ: state_d = ST_CMP;

      ST_CMP: begin
        if (!a_ok && !b_ok) begin
          // Both lists drained: flush the held term or the empty marker.
          if (slot_free) begin
            out_vld_d          = 1'b1;
            out_d.sum_coef     = pend_vld_q ? pend_coef_q : 17'sd0;
            out_d.sum_exponent = pend_vld_q ? pend_expo_q : 8'd0;
            out_d.is_empty     = !pend_vld_q;
            out_d.truncated    = 1'b0;
            out_d.last         = 1'b1;
            cnt_a_d            = '0;
            cnt_b_d            = '0;
            state_d            = ST_IDLE;
          end
        end else if (cand_coef == 17'sd0) begin
          // Cancelled pair, nothing to emit.
          i_d     = i_q + CW'(take_a);
          j_d     = j_q + CW'(take_b);
          state_d = ST_READ;
        end else if (!pend_vld_q) begin
          pend_vld_d  = 1'b1;
          pend_coef_d = cand_coef;
          pend_expo_d = cand_expo;
          n_d         = CW'(1);
          i_d         = i_q + CW'(take_a);
          j_d         = j_q + CW'(take_b);
          state_d     = ST_READ;
        end else if (slot_free) begin
          out_vld_d          = 1'b1;
          out_d.sum_coef     = pend_coef_q;
          out_d.sum_exponent = pend_expo_q;
          out_d.is_empty     = 1'b0;
          if (n_q == CapCnt) begin
            // Cap reached and another term waits: close out truncated.
            out_d.truncated = 1'b1;
            out_d.last      = 1'b1;
            cnt_a_d         = '0;
            cnt_b_d         = '0;
            state_d         = ST_IDLE;
          end else begin
            out_d.truncated = 1'b0;
            out_d.last      = 1'b0;
            pend_coef_d     = cand_coef;
            pend_expo_d     = cand_expo;
            n_d             = n_q + 1'b1;
            i_d             = i_q + CW'(take_a);
            j_d             = j_q + CW'(take_b);
            state_d         = ST_READ;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      i_q        <= '0;
      j_q        <= '0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      i_q        <= i_d;
      j_q        <= j_d;
      n_q        <= n_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_coef_q <= pend_coef_d;
    pend_expo_q <= pend_expo_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: design/spm_checker.sv
// ---------------------------------------------------------------------------
// spm_checker
// Port-level checks on the merge block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spm_checker import spm_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire in_req_t  in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire out_rsp_t out_rsp_o
);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output request dropped before taken")
  `ASSERT_RST(a_merge_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (in_req_i.opcode == OP_MERGE) |=> !in_ready_o, "ready after merge request")
  `ASSERT_RST(a_load_ready, clk_i, rst_ni, in_valid_i && in_ready_o && (in_req_i.opcode != OP_MERGE) |=> in_ready_o, "load request stalled the input")
  `ASSERT_ALWAYS(a_trunc_last, clk_i, !(rst_ni && out_valid_o && out_rsp_o.truncated) || (out_rsp_o.last && !out_rsp_o.is_empty), "truncated off a final term")

endmodule

bind sparse_polynomial_add_merge spm_checker u_spm_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks sparse_polynomial_add_merge against a term-list model of its own.
// Loads and merge requests are queued up front and driven with bursty
// timing; every merged term coming out is compared field by field with the
// oldest predicted term, while the output side stalls on its own pattern.
// ---------------------------------------------------------------------------

module tb_top;
  import spm_pkg::*;

  localparam int TERM_CAP     = 16;
  localparam int STIM_ITEMS   = 250;
  localparam int HOLD_AFTER   = 60;   // results seen before the long stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * (2 * TERM_CAP) + 20;
  localparam int LIMIT_CYCLES = 300000;

  // Opcode with no meaning; the block must leave its state alone.
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_e;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     in_ready;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  always #5 clk_i = ~clk_i;

  sparse_polynomial_add_merge #(
    .MAX_TERMS(TERM_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // -------------------------------------------------------------------------
  // Term-list model
  // -------------------------------------------------------------------------
  term_t    poly_a [TERM_CAP];
  term_t    poly_b [TERM_CAP];
  int       cnt_a = 0;
  int       cnt_b = 0;
  out_rsp_t expected_terms[$];

  // Walks both lists head by head, the way the block does.
  task automatic merge_term_lists();
    int       ia, ib, n, k, coef;
    logic [7:0] expo;
    bit       trunc, stop;
    out_rsp_t rsp;
    out_rsp_t outs [TERM_CAP];
    ia = 0; ib = 0; n = 0; trunc = 0; stop = 0;
    while (!stop && (ia < cnt_a || ib < cnt_b)) begin
      if (ia < cnt_a && ib < cnt_b && poly_a[ia].expo == poly_b[ib].expo) begin
        coef = int'(poly_a[ia].coef) + int'(poly_b[ib].coef);
        expo = poly_a[ia].expo;
        ia++;
        ib++;
      end else if (ib >= cnt_b || (ia < cnt_a && poly_a[ia].expo > poly_b[ib].expo)) begin
        coef = int'(poly_a[ia].coef);
        expo = poly_a[ia].expo;
        ia++;
      end else begin
        coef = int'(poly_b[ib].coef);
        expo = poly_b[ib].expo;
        ib++;
      end
      // cancelled terms vanish; a live term past the cap flags truncation
      if (coef != 0) begin
        if (n >= TERM_CAP) begin
          trunc = 1;
          stop  = 1;
        end else begin
          rsp              = '0;
          rsp.sum_coef     = 17'(coef);
          rsp.sum_exponent = expo;
          outs[n]          = rsp;
          n++;
        end
      end
    end
    if (n == 0) begin
      rsp          = '0;
      rsp.is_empty = 1'b1;
      rsp.last     = 1'b1;
      expected_terms.push_back(rsp);
    end else begin
      for (k = 0; k < n; k++) begin
        rsp = outs[k];
        if (k == n - 1) begin
          rsp.truncated = trunc;
          rsp.last      = 1'b1;
        end
        expected_terms.push_back(rsp);
      end
    end
    cnt_a = 0;
    cnt_b = 0;
  endtask

  task automatic apply_request(in_req_t r);
    case (r.opcode)
      OP_LOAD_A: begin
        if (r.term_coef != 0 && cnt_a < TERM_CAP) begin
          poly_a[cnt_a] = {r.term_coef, r.term_exponent};
          cnt_a++;
        end
      end
      OP_LOAD_B: begin
        if (r.term_coef != 0 && cnt_b < TERM_CAP) begin
          poly_b[cnt_b] = {r.term_coef, r.term_exponent};
          cnt_b++;
        end
      end
      OP_MERGE: merge_term_lists();
      default: ;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Request generation
  // -------------------------------------------------------------------------
  in_req_t pending_reqs[$];
  int      stim_count = 0;

  function automatic void push_req(logic [1:0] op, logic signed [15:0] coef,
                                   logic [7:0] expo);
    in_req_t r;
    r.opcode        = op;
    r.term_coef     = coef;
    r.term_exponent = expo;
    pending_reqs.push_back(r);
    // zero-coefficient loads and the unused opcode do not count toward the stimulus length
    if (op == OP_MERGE || ((op == OP_LOAD_A || op == OP_LOAD_B) && coef != 0))
      stim_count++;
  endfunction

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd1;
      3: return -16'sd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Loads na terms into A and nb into B with strictly falling exponents;
  // some exponents are shared, some of those cancel.
  task automatic push_terms(int na, int nb);
    int ia, ib, left, cur, room, role;
    logic signed [15:0] ca, cb;
    ia  = 0;
    ib  = 0;
    cur = $urandom_range(na + nb, 255);
    while (ia < na || ib < nb) begin
      if (ia < na && ib < nb) role = $urandom_range(0, 2);
      else if (ia < na)       role = 0;
      else                    role = 1;
      ca = pick_coef();
      cb = pick_coef();
      if (role == 2 && ca != 16'sh8000 && $urandom_range(0, 2) == 0) cb = -ca;
      if (role != 1) begin
        push_req(OP_LOAD_A, ca, 8'(cur));
        ia++;
      end
      if (role != 0) begin
        push_req(OP_LOAD_B, cb, 8'(cur));
        ib++;
      end
      if ($urandom_range(0, 19) == 0)
        push_req($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, 16'sd0, 8'($urandom));
      // keep enough exponent room for the terms still to come
      left = (na - ia) + (nb - ib);
      room = cur - left + 1;
      cur  = cur - $urandom_range(1, (room < 20) ? room : 20);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps
  // -------------------------------------------------------------------------
  logic in_took    = 1'b0;
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid && in_ready;
    if (rst_ni && in_valid && in_ready) apply_request(in_req);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        in_req   <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall pattern, plus one long hold-off to back up the block
  // -------------------------------------------------------------------------
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_left      = 0;
  int       hold_left    = 0;
  bit       hold_done    = 1'b0;
  int       results_seen = 0;

  always @(posedge clk_i) begin
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(32, 256);
      end else begin
        rx_left <= rx_left - 1;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= rx_left[1];
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor
  // -------------------------------------------------------------------------
  int mismatches = 0;

  always @(posedge clk_i) begin : monitor
    out_rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_terms.size() == 0) begin
        $error("unexpected result: sum_coef %0d sum_exponent %0d",
               out_rsp.sum_coef, out_rsp.sum_exponent);
        mismatches++;
      end else begin
        want = expected_terms.pop_front();
        if (out_rsp.sum_coef !== want.sum_coef) begin
          $error("sum_coef: expected %0d, actual %0d", want.sum_coef, out_rsp.sum_coef);
          mismatches++;
        end
        if (out_rsp.sum_exponent !== want.sum_exponent) begin
          $error("sum_exponent: expected %0d, actual %0d",
                 want.sum_exponent, out_rsp.sum_exponent);
          mismatches++;
        end
        if (out_rsp.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, actual %0b", want.is_empty, out_rsp.is_empty);
          mismatches++;
        end
        if (out_rsp.truncated !== want.truncated) begin
          $error("truncated: expected %0b, actual %0b", want.truncated, out_rsp.truncated);
          mismatches++;
        end
        if (out_rsp.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_rsp.last);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Timeout
  // -------------------------------------------------------------------------
  int cycle_count = 0;

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL sparse_polynomial_add_merge");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int kind, na, nb, k, n;
    logic [1:0] op;

    // empty lists give the marker item
    push_req(OP_MERGE, 16'sd0, 8'd0);
    // extreme coefficients and exponents, sums at both ends of the range,
    // zero-coefficient loads and the unused opcode in between
    push_req(OP_LOAD_A, 16'sh7fff, 8'd255);
    push_req(OP_LOAD_A, 16'sh8000, 8'd128);
    push_req(OP_LOAD_A, 16'sd1, 8'd0);
    push_req(OP_LOAD_B, 16'sh7fff, 8'd255);
    push_req(OP_LOAD_B, 16'sh8000, 8'd128);
    push_req(OP_LOAD_B, 16'sd0, 8'd7);
    push_req(OP_NONE, -16'sd1, 8'd255);
    push_req(OP_LOAD_A, 16'sd0, 8'd200);
    push_req(OP_LOAD_B, -16'sd1, 8'd3);
    push_req(OP_MERGE, 16'sh7fff, 8'd255);
    // all terms cancel: marker item again
    push_req(OP_LOAD_A, 16'sd5, 8'd10);
    push_req(OP_LOAD_B, -16'sd5, 8'd10);
    push_req(OP_MERGE, 16'sd0, 8'd0);
    // rising exponents in A, merged as they stand
    push_req(OP_LOAD_A, 16'sd7, 8'd3);
    push_req(OP_LOAD_A, -16'sd9, 8'd9);
    push_req(OP_LOAD_B, 16'sd4, 8'd5);
    push_req(OP_LOAD_B, 16'sd100, 8'd200);
    push_req(OP_MERGE, 16'sd0, 8'd0);
    // B alone
    push_req(OP_LOAD_B, 16'sd12, 8'd40);
    push_req(OP_MERGE, 16'sd0, 8'd0);
    // alternating bit patterns
    push_req(OP_LOAD_A, 16'sh5555, 8'haa);
    push_req(OP_LOAD_B, 16'shaaaa, 8'h55);
    push_req(OP_MERGE, 16'shffff, 8'hff);

    // lists near or past the cap, which may drop loads and truncate the merge, up front
    push_terms($urandom_range(15, 20), $urandom_range(15, 20));
    push_req(OP_MERGE, 16'($urandom), 8'($urandom));

    while (stim_count < STIM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        push_terms($urandom_range(15, 20), $urandom_range(15, 20));
        push_req(OP_MERGE, 16'($urandom), 8'($urandom));
      end else if (kind < 78) begin
        na = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 6);
        nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 6);
        push_terms(na, nb);
        push_req(OP_MERGE, 16'($urandom), 8'($urandom));
      end else begin
        // noise: any opcode, any order, any content
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          op = 2'($urandom_range(0, 3));
          push_req(op, ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 9) < 7) push_req(OP_MERGE, 16'($urandom), 8'($urandom));
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_terms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("PASS sparse_polynomial_add_merge");
    end else begin
      if (expected_terms.size() != 0)
        $error("%0d expected results never arrived", expected_terms.size());
      $display("FAIL sparse_polynomial_add_merge");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/spm_pkg.sv
design/spm_term_mem.sv
design/spm_merge_ctrl.sv
design/sparse_polynomial_add_merge.sv
design/spm_checker.sv
test/tb_top.sv
